### rtl/core/rmez_pkg.sv
package rmez_pkg;

  localparam int CORDIC_STAGES = 16;
  localparam int TABLE_LEN     = 24;
  localparam int NSTG          = (CORDIC_STAGES > TABLE_LEN) ? TABLE_LEN : CORDIC_STAGES;
  localparam int SQRT_STEPS    = 16;

  localparam int XW = 40;
  localparam int ZW = 32;

  localparam logic signed [ZW-1:0] PI_Q24    = 32'sd52707179;
  localparam logic signed [ZW-1:0] ANGLE_MAX = 32'sd25736;

  typedef struct packed {
    logic signed [15:0] r00;
    logic signed [15:0] r10;
    logic signed [15:0] r20;
    logic signed [15:0] r21;
    logic signed [15:0] r22;
    logic signed [15:0] r11;
    logic signed [15:0] r12;
  } rmez_mat_t;

  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
    logic                 zero;
  } rmez_vec_t;

  function automatic logic signed [ZW-1:0] atan_lut(input logic [4:0] idx);
    logic signed [ZW-1:0] a;
    case (idx)
      5'd0:    a = 32'sd13176795;
      5'd1:    a = 32'sd7778716;
      5'd2:    a = 32'sd4110060;
      5'd3:    a = 32'sd2086331;
      5'd4:    a = 32'sd1047214;
      5'd5:    a = 32'sd524117;
      5'd6:    a = 32'sd262123;
      5'd7:    a = 32'sd131069;
      5'd8:    a = 32'sd65536;
      5'd9:    a = 32'sd32768;
      5'd10:   a = 32'sd16384;
      5'd11:   a = 32'sd8192;
      5'd12:   a = 32'sd4096;
      5'd13:   a = 32'sd2048;
      5'd14:   a = 32'sd1024;
      5'd15:   a = 32'sd512;
      5'd16:   a = 32'sd256;
      5'd17:   a = 32'sd128;
      5'd18:   a = 32'sd64;
      5'd19:   a = 32'sd32;
      5'd20:   a = 32'sd16;
      5'd21:   a = 32'sd8;
      5'd22:   a = 32'sd4;
      5'd23:   a = 32'sd2;
      default: a = '0;
    endcase
    return a;
  endfunction

  // fold the left half-plane onto the right and seed the angle with +-pi
  function automatic rmez_vec_t cordic_init(input logic signed [16:0] y,
                                            input logic signed [16:0] x);
    rmez_vec_t v;
    logic signed [XW-1:0] xw;
    logic signed [XW-1:0] yw;
    xw = {{7{x[16]}}, x, 16'b0};
    yw = {{7{y[16]}}, y, 16'b0};
    v.zero = (x == '0) && (y == '0);
    if (x[16]) begin
      v.x = -xw;
      v.y = -yw;
      v.z = y[16] ? -PI_Q24 : PI_Q24;
    end else begin
      v.x = xw;
      v.y = yw;
      v.z = '0;
    end
    return v;
  endfunction

  function automatic logic signed [15:0] angle_out(input logic signed [ZW-1:0] z);
    logic signed [ZW-1:0] r;
    r = (z + 32'sd1024) >>> 11;
    if (r > ANGLE_MAX) r = ANGLE_MAX;
    if (r < -ANGLE_MAX) r = -ANGLE_MAX;
    return r[15:0];
  endfunction

endpackage

### rtl/core/rmez_in_if.sv
interface rmez_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] r00;
  logic signed [15:0] r10;
  logic signed [15:0] r20;
  logic signed [15:0] r21;
  logic signed [15:0] r22;
  logic signed [15:0] r11;
  logic signed [15:0] r12;

  modport source (output valid, r00, r10, r20, r21, r22, r11, r12, input ready);
  modport sink (input valid, r00, r10, r20, r21, r22, r11, r12, output ready);
endinterface

### rtl/core/rmez_out_if.sv
interface rmez_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] yaw;
  logic signed [15:0] pitch;
  logic signed [15:0] roll;
  logic               singular;

  modport source (output valid, yaw, pitch, roll, singular, input ready);
  modport sink (input valid, yaw, pitch, roll, singular, output ready);
endinterface

### rtl/core/rmez_sqrt_cell.sv
module rmez_sqrt_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic [3:0]          idx_i,
  input  logic                valid_i,
  input  logic [31:0]         rem_i,
  input  logic [31:0]         res_i,
  input  rmez_pkg::rmez_mat_t mat_i,
  output logic                valid_o,
  output logic [31:0]         rem_o,
  output logic [31:0]         res_o,
  output rmez_pkg::rmez_mat_t mat_o
);
  import rmez_pkg::*;

  logic [31:0] bit_w;
  logic [31:0] trial;
  logic [31:0] rem_d, res_d;
  logic        valid_q;
  logic [31:0] rem_q, res_q;
  rmez_mat_t   mat_q;

  assign bit_w = 32'h4000_0000 >> {idx_i, 1'b0};
  assign trial = res_i + bit_w;

  always_comb begin
    if (rem_i >= trial) begin
      rem_d = rem_i - trial;
      res_d = (res_i >> 1) + bit_w;
    end else begin
      rem_d = rem_i;
      res_d = res_i >> 1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q <= rem_d;
      res_q <= res_d;
      mat_q <= mat_i;
    end
  end

  assign valid_o = valid_q;
  assign rem_o   = rem_q;
  assign res_o   = res_q;
  assign mat_o   = mat_q;
endmodule

### rtl/core/rmez_cordic_cell.sv
module rmez_cordic_cell (
  input  logic                clk_i,
  input  logic                en_i,
  input  logic [4:0]          idx_i,
  input  rmez_pkg::rmez_vec_t vec_i,
  output rmez_pkg::rmez_vec_t vec_o
);
  import rmez_pkg::*;

  logic signed [XW-1:0] xs, ys;
  rmez_vec_t            vec_d, vec_q;

  assign xs = vec_i.x >>> idx_i;
  assign ys = vec_i.y >>> idx_i;

  always_comb begin
    vec_d.zero = vec_i.zero;
    if (!vec_i.y[XW-1]) begin
      vec_d.x = vec_i.x + ys;
      vec_d.y = vec_i.y - xs;
      vec_d.z = vec_i.z + atan_lut(idx_i);
    end else begin
      vec_d.x = vec_i.x - ys;
      vec_d.y = vec_i.y + xs;
      vec_d.z = vec_i.z - atan_lut(idx_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      vec_q <= vec_d;
    end
  end

  assign vec_o = vec_q;
endmodule

### rtl/core/rotation_matrix_to_euler_zyx.sv
// Z-Y-X Euler extraction from seven Q1.14 rotation-matrix entries, giving
// yaw, pitch and roll as Q2.13 radians plus a gimbal-lock flag. The block
// is a fully pipelined chain: a register for the squares, another for their
// sum, 16 square-root cells, a set-up register, 16 CORDIC cells on three
// parallel lanes and an output register, and a new word is taken every
// cycle. The whole chain holds while the output register is full and not
// taken. limit_q resets to 1.
module rotation_matrix_to_euler_zyx (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [14:0] cfg_data_i,
  rmez_in_if.sink     in_i,
  rmez_out_if.source  out_o
);
  import rmez_pkg::*;

  logic        en;
  logic [14:0] limit_q;

  logic               vp_q, vs_q;
  logic signed [31:0] p00_q, p10_q;
  rmez_mat_t          matp_q, mats_q, mat_in;
  logic [31:0]        sum_q;

  logic        sv   [SQRT_STEPS+1];
  logic [31:0] srem [SQRT_STEPS+1];
  logic [31:0] sres [SQRT_STEPS+1];
  rmez_mat_t   smat [SQRT_STEPS+1];

  logic        vu_q, singu_q;
  logic [15:0] sy;
  logic        sing_w;
  rmez_mat_t   mu;

  rmez_vec_t cinit_q [3];
  rmez_vec_t cv [3][NSTG+1];
  logic      cvalid_q [NSTG];
  logic      csing_q  [NSTG];

  logic               out_valid_q, sing_out_q;
  logic signed [15:0] yaw_q, pitch_q, roll_q;

  assign en         = !out_valid_q || out_o.ready;
  assign in_i.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= 15'd1;
    end else if (cfg_we_i) begin
      limit_q <= cfg_data_i;
    end
  end

  assign mat_in = '{r00: in_i.r00, r10: in_i.r10, r20: in_i.r20, r21: in_i.r21,
                    r22: in_i.r22, r11: in_i.r11, r12: in_i.r12};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vp_q <= 1'b0;
      vs_q <= 1'b0;
    end else if (en) begin
      vp_q <= in_i.valid;
      vs_q <= vp_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p00_q  <= 32'(in_i.r00 * in_i.r00);
      p10_q  <= 32'(in_i.r10 * in_i.r10);
      matp_q <= mat_in;
      sum_q  <= p00_q + p10_q;
      mats_q <= matp_q;
    end
  end

  assign sv[0]   = vs_q;
  assign srem[0] = sum_q;
  assign sres[0] = '0;
  assign smat[0] = mats_q;

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
    rmez_sqrt_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .idx_i   (4'(k)),
      .valid_i (sv[k]),
      .rem_i   (srem[k]),
      .res_i   (sres[k]),
      .mat_i   (smat[k]),
      .valid_o (sv[k+1]),
      .rem_o   (srem[k+1]),
      .res_o   (sres[k+1]),
      .mat_o   (smat[k+1])
    );
  end

  assign sy     = sres[SQRT_STEPS][15:0];
  assign mu     = smat[SQRT_STEPS];
  assign sing_w = sy < {1'b0, limit_q};

  // pick the operand pairs once the singular decision is known
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vu_q <= 1'b0;
    end else if (en) begin
      vu_q <= sv[SQRT_STEPS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      singu_q    <= sing_w;
      cinit_q[0] <= cordic_init({mu.r10[15], mu.r10}, {mu.r00[15], mu.r00});
      cinit_q[1] <= cordic_init(-{mu.r20[15], mu.r20}, {1'b0, sy});
      if (sing_w) begin
        cinit_q[2] <= cordic_init(-{mu.r12[15], mu.r12}, {mu.r11[15], mu.r11});
      end else begin
        cinit_q[2] <= cordic_init({mu.r21[15], mu.r21}, {mu.r22[15], mu.r22});
      end
    end
  end

  for (genvar l = 0; l < 3; l++) begin : g_lane
    assign cv[l][0] = cinit_q[l];
    for (genvar j = 0; j < NSTG; j++) begin : g_stage
      rmez_cordic_cell u_cell (
        .clk_i (clk_i),
        .en_i  (en),
        .idx_i (5'(j)),
        .vec_i (cv[l][j]),
        .vec_o (cv[l][j+1])
      );
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < NSTG; j++) cvalid_q[j] <= 1'b0;
    end else if (en) begin
      cvalid_q[0] <= vu_q;
      for (int j = 1; j < NSTG; j++) cvalid_q[j] <= cvalid_q[j-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      csing_q[0] <= singu_q;
      for (int j = 1; j < NSTG; j++) csing_q[j] <= csing_q[j-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= cvalid_q[NSTG-1];
    end
  end

  // zero operands and a singular yaw both give a zero angle
  always_ff @(posedge clk_i) begin
    if (en) begin
      sing_out_q <= csing_q[NSTG-1];
      yaw_q      <= (csing_q[NSTG-1] || cv[0][NSTG].zero) ? '0 : angle_out(cv[0][NSTG].z);
      pitch_q    <= cv[1][NSTG].zero ? '0 : angle_out(cv[1][NSTG].z);
      roll_q     <= cv[2][NSTG].zero ? '0 : angle_out(cv[2][NSTG].z);
    end
  end

  assign out_o.valid    = out_valid_q;
  assign out_o.yaw      = yaw_q;
  assign out_o.pitch    = pitch_q;
  assign out_o.roll     = roll_q;
  assign out_o.singular = sing_out_q;
endmodule
